// File: design/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg: shared types and constants for the modulation matrix smoother
// Frame word layout, divider request/response, fixed-point constants and
// the 2^(-2^-k) factor table used by the exp2 iteration.
// ----------------------------------------------------------------------------
package mms_pkg;

	localparam int NUM_REGS  = 8;
	localparam int IDX_W     = 3;
	localparam int ROUTE_W   = 63;
	localparam int SRC_N     = 8;
	localparam int SRC_W     = 16;
	localparam int DT_W      = 24;
	localparam int TDATA_W   = SRC_N * SRC_W + DT_W;
	localparam int RCNT_W    = 4;
	localparam int DIV_NW    = 56;
	localparam int DIV_DW    = 24;

	localparam int ROUTES_DEF       = 8;
	localparam int DESTINATIONS_DEF = 8;
	localparam int SOURCES_DEF      = 8;

	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	typedef struct packed {
		logic [SRC_N-1:0][SRC_W-1:0] src;
		logic [DT_W-1:0]             dt;
		logic                        dt_zero;
	} frame_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] numer;
		logic [DIV_DW-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} div_rsp_t;

	typedef logic [30:0][30:0] pow_tbl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// entry k (k >= 1) holds 2^(-2^-k) in Q30, built by repeated floor square roots; entry 0 holds 1.0
	function automatic pow_tbl_t build_pow_tbl();
		pow_tbl_t    t;
		logic [63:0] prev;
		t[0] = Q30_ONE;
		prev = isqrt64(64'd1 << 59);
		t[1] = prev[30:0];
		for (int k = 2; k <= 30; k++) begin
			prev = isqrt64(prev << 30);
			t[k] = prev[30:0];
		end
		return t;
	endfunction

	localparam pow_tbl_t POW_TBL = build_pow_tbl();

endpackage

// File: design/modulation_matrix_smoother_top.sv
// Flow: per frame, each route is skipped if unused, accumulated directly
// for a zero curve, or shaped through 16 log2 squarings and 30 exp2 steps
// on one multiplier, after a divider wait for a negative curve; then each
// destination is updated directly if unsmoothed, or after the divider and
// exp2 if smoothed. Throughput: one frame at a time, and the output can stall;
// two more frames queue in front. Reset: arst_n clears routes, state.
// ----------------------------------------------------------------------------
// modulation_matrix_smoother_top: modulation matrix with one-pole smoothing
// Eight route registers map eight Q1.15 sources, through a signed power
// curve and an amount, onto destinations; each destination eases toward
// its saturated target and one word per destination is sent out.
// ----------------------------------------------------------------------------
module modulation_matrix_smoother_top import mms_pkg::*; #(
	parameter int ROUTES       = ROUTES_DEF,
	parameter int DESTINATIONS = DESTINATIONS_DEF,
	parameter int SOURCES      = SOURCES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// source_0 .. source_7 (16 bits each), frame_time (24 bits)
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	// value (16 bits)
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,
	// destination (3 bits)
	output logic [2:0]         m_tuser,
	output logic               m_tlast,
	// route register writes
	input  logic               cfg_wr_en,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [ROUTE_W-1:0] cfg_data
);

	// route register file: enable, source, destination, amount, curve, time
	logic [NUM_REGS-1:0][ROUTE_W-1:0] route_q;

	frame_t   frm;
	logic     frm_valid;
	logic     frm_ready;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_q <= '0;
		end else if (cfg_wr_en) begin
			route_q[cfg_index] <= cfg_data;
		end
	end

	// front: unpack frame words and queue them
	mms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.frm       (frm),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready)
	);

	// shared divider: curve exponent and dt/T
	mms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// back: route pass, destination pass, output register
	mms_engine #(
		.ROUTES       (ROUTES),
		.DESTINATIONS (DESTINATIONS),
		.SOURCES      (SOURCES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm       (frm),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.routes    (route_q),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: design/mms_front.sv
// ----------------------------------------------------------------------------
// mms_front: input side of the smoother
// Accepts frame words, unpacks and tags them, and queues them (two deep)
// for the engine.
// ----------------------------------------------------------------------------
module mms_front import mms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	output frame_t             frm,
	output logic               frm_valid,
	input  logic               frm_ready
);

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	frame_t     incoming;
	logic       push;
	logic       pop;

	always_comb begin
		for (int i = 0; i < SRC_N; i++) begin
			incoming.src[i] = s_tdata[SRC_W*i +: SRC_W];
		end
		incoming.dt      = s_tdata[TDATA_W-1 -: DT_W];
		incoming.dt_zero = (incoming.dt == '0);
	end

	assign s_tready  = (count_q != 2'd2);
	assign frm_valid = (count_q != 2'd0);
	assign frm       = mem_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = frm_valid && frm_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("frame queue count overflow");

endmodule

// File: design/mms_div.sv
// ----------------------------------------------------------------------------
// mms_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses after the
// last bit.
// ----------------------------------------------------------------------------
module mms_div import mms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_sh;
	logic              fits;

	assign rem_sh   = {rem_q, quo_q[DIV_NW-1]};
	assign fits     = (rem_sh >= {1'b0, den_q});
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.numer;
			den_q <= req.denom;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

endmodule

// File: design/mms_engine.sv
// ----------------------------------------------------------------------------
// mms_engine: back end of the smoother
// Walks the routes (shape curve, scale, accumulate) and then the
// destinations (saturate, smoothing coefficient, state update, emit), on
// one shared multiplier and the external divider.
// ----------------------------------------------------------------------------
module mms_engine import mms_pkg::*; #(
	parameter int ROUTES       = ROUTES_DEF,
	parameter int DESTINATIONS = DESTINATIONS_DEF,
	parameter int SOURCES      = SOURCES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  frame_t                           frm,
	input  logic                             frm_valid,
	output logic                             frm_ready,
	input  logic [NUM_REGS-1:0][ROUTE_W-1:0] routes,
	output div_req_t                         div_req,
	input  div_rsp_t                         div_rsp,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,
	output logic [2:0]                       m_tuser,
	output logic                             m_tlast
);

	localparam int DIDX_W = (DESTINATIONS > 1) ? $clog2(DESTINATIONS) : 1;
	localparam int DCNT_W = $clog2(DESTINATIONS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_R_LOAD, ST_R_EDIV, ST_R_LOG, ST_R_LMUL, ST_X_LOOP, ST_X_SHIFT,
		ST_R_ACC, ST_D_LOAD, ST_D_DIV, ST_D_UPD, ST_D_EMIT
	} state_t;

	state_t                         state_q;
	logic [RCNT_W-1:0]              rc_q;
	logic [DCNT_W-1:0]              d_q;
	logic [SRC_N-1:0][SRC_W-1:0]    src_q;
	logic [DT_W-1:0]                dt_q;
	logic                           dtz_q;
	logic [2:0]                     dst_q;
	logic signed [15:0]             amt_q;
	logic                           neg_q;
	logic [30:0]                    y_q;
	logic [3:0]                     p_q;
	logic [15:0]                    frac_q;
	logic [3:0]                     cnt_q;
	logic [17:0]                    e16_q;
	logic [DIV_NW-1:0]              ey_q;
	logic [4:0]                     k_q;
	logic [30:0]                    rexp_q;
	logic                           dest_q;
	logic signed [24:0]             shaped_q;
	logic signed [42:0]             acc_q [DESTINATIONS];
	logic [23:0]                    tsm_q [DESTINATIONS];
	logic signed [23:0]             sm_q  [DESTINATIONS];
	logic signed [23:0]             t_q;
	logic [30:0]                    alpha_q;
	logic [15:0]                    val_q;
	logic                           m_tvalid_q;
	logic [15:0]                    m_tdata_q;
	logic [2:0]                     m_tuser_q;
	logic                           m_tlast_q;

	// route decode
	logic [ROUTE_W-1:0]  rreg;
	logic                r_live;
	logic [2:0]          r_src;
	logic [2:0]          r_dst;
	logic [15:0]         r_amt;
	logic [15:0]         r_cur;
	logic [23:0]         r_tsm;
	logic [15:0]         r_x;
	logic [16:0]         xe;
	logic [16:0]         r_mag;
	logic [3:0]          r_p;
	logic [30:0]         r_y;
	logic [16:0]         cur_abs;
	logic [17:0]         r_den;
	logic [17:0]         e16_pos;
	logic [DIDX_W-1:0]   r_didx;

	// shared multiplier
	logic signed [33:0]  mul_a;
	logic signed [33:0]  mul_b;
	logic signed [67:0]  mul_p;

	// step datapath
	logic [31:0]         y2;
	logic [19:0]         lneg;
	logic [29:0]         ey_frac;
	logic                fbit;
	logic [62:0]         rnd;
	logic [25:0]         ip;
	logic [30:0]         rs;
	logic [23:0]         mag;
	logic [DIDX_W-1:0]   d_idx;
	logic signed [42:0]  acc_d;
	logic signed [43:0]  acc_x;
	logic signed [43:0]  t_w;
	logic signed [23:0]  t_sat;
	logic signed [23:0]  s_cur;
	logic signed [24:0]  diff;
	logic signed [67:0]  adj_full;
	logic signed [26:0]  s_new;
	logic signed [23:0]  s_sat;
	logic signed [24:0]  v_w;
	logic [15:0]         v_sat;
	logic                d_smooth;

	assign rreg    = routes[rc_q[IDX_W-1:0]];
	assign r_src   = rreg[3:1];
	assign r_dst   = rreg[6:4];
	assign r_amt   = rreg[22:7];
	assign r_cur   = rreg[38:23];
	assign r_tsm   = rreg[62:39];
	assign r_live  = rreg[0] && ({1'b0, r_dst} < 4'(DESTINATIONS));
	assign r_didx  = r_dst[DIDX_W-1:0];
	assign r_x     = ({1'b0, r_src} < 4'(SOURCES)) ? src_q[r_src] : '0;
	assign xe      = {r_x[15], r_x};
	assign r_mag   = xe[16] ? 17'(-xe) : xe;
	assign r_y     = 31'(r_mag) << (5'd30 - {1'b0, r_p});
	assign cur_abs = 17'(-{r_cur[15], r_cur});
	assign r_den   = 18'(32'd32768 + 32'd3 * 32'(cur_abs));
	assign e16_pos = 18'((32'd32768 + 32'd3 * 32'(r_cur[14:0])) << 1);

	always_comb begin
		r_p = '0;
		for (int i = 0; i < 16; i++) begin
			if (r_mag[i]) r_p = 4'(i);
		end
	end

	assign d_idx    = d_q[DIDX_W-1:0];
	assign acc_d    = acc_q[d_idx];
	assign s_cur    = sm_q[d_idx];
	assign d_smooth = (tsm_q[d_idx] != '0) && !dtz_q;

	always_comb begin
		case (state_q)
			ST_R_LOG: begin
				mul_a = $signed({3'b0, y_q});
				mul_b = $signed({3'b0, y_q});
			end
			ST_R_LMUL: begin
				mul_a = $signed({14'b0, lneg});
				mul_b = $signed({16'b0, e16_q});
			end
			ST_X_LOOP: begin
				mul_a = $signed({3'b0, rexp_q});
				mul_b = $signed({3'b0, POW_TBL[k_q]});
			end
			ST_R_ACC: begin
				mul_a = $signed({{18{amt_q[15]}}, amt_q});
				mul_b = $signed({{9{shaped_q[24]}}, shaped_q});
			end
			ST_D_LOAD: begin
				mul_a = $signed({10'b0, dt_q});
				mul_b = $signed({3'b0, LOG2E_Q30});
			end
			ST_D_UPD: begin
				mul_a = $signed({3'b0, alpha_q});
				mul_b = $signed({{9{diff[24]}}, diff});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// log2 squaring, exponent, exp2 factor steps
	assign y2      = mul_p[61:30];
	assign lneg    = 20'd983040 - {p_q, frac_q};
	assign ey_frac = ey_q[29:0];
	assign fbit    = ey_frac[5'(5'd30 - k_q)];
	assign rnd     = 63'(mul_p[61:0]) + 63'(32'h2000_0000);
	assign ip      = ey_q[DIV_NW-1:30];
	assign rs      = (ip >= 26'd31) ? '0 : (rexp_q >> ip[4:0]);
	assign mag     = 24'((32'(rs) + 32'd64) >> 7);

	// target and state update
	assign acc_x = $signed({acc_d[42], acc_d});
	assign t_w   = (acc_x + 44'sd16384) >>> 15;
	always_comb begin
		if (t_w > 44'sd8388607) t_sat = 24'sh7fffff;
		else if (t_w < -44'sd8388608) t_sat = -24'sh800000;
		else t_sat = t_w[23:0];
	end

	assign diff     = $signed({t_q[23], t_q}) - $signed({s_cur[23], s_cur});
	assign adj_full = (mul_p + 68'sd536870912) >>> 30;
	assign s_new    = $signed({{3{s_cur[23]}}, s_cur}) + adj_full[26:0];
	always_comb begin
		if (s_new > 27'sd8388607) s_sat = 24'sh7fffff;
		else if (s_new < -27'sd8388608) s_sat = -24'sh800000;
		else s_sat = s_new[23:0];
	end
	assign v_w   = ($signed({s_sat[23], s_sat}) + 25'sd128) >>> 8;
	assign v_sat = (v_w > 25'sd32767) ? 16'h7fff : v_w[15:0];

	always_comb begin
		div_req.start = 1'b0;
		div_req.numer = '0;
		div_req.denom = '0;
		case (state_q)
			ST_R_LOAD: begin
				div_req.start = (rc_q != RCNT_W'(ROUTES)) && r_live && (r_cur != '0) &&
					(r_x != '0) && r_cur[15];
				div_req.numer = DIV_NW'(64'h8000_0000 + 64'(r_den >> 1));
				div_req.denom = DIV_DW'(r_den);
			end
			ST_D_LOAD: begin
				div_req.start = (d_q != DCNT_W'(DESTINATIONS)) && d_smooth;
				div_req.numer = mul_p[DIV_NW-1:0];
				div_req.denom = tsm_q[d_idx];
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign frm_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < DESTINATIONS; i++) begin
				sm_q[i] <= '0;
			end
		end else begin
			// the emit state reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != ST_D_EMIT) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (frm_valid) begin
						src_q <= frm.src;
						dt_q  <= frm.dt;
						dtz_q <= frm.dt_zero;
						rc_q  <= '0;
						for (int i = 0; i < DESTINATIONS; i++) begin
							acc_q[i] <= '0;
							tsm_q[i] <= '0;
						end
						state_q <= ST_R_LOAD;
					end
				end
				ST_R_LOAD: begin
					if (rc_q == RCNT_W'(ROUTES)) begin
						d_q     <= '0;
						state_q <= ST_D_LOAD;
					end else if (!r_live) begin
						rc_q <= rc_q + 1'b1;
					end else begin
						dst_q  <= r_dst;
						amt_q  <= r_amt;
						neg_q  <= r_x[15];
						y_q    <= r_y;
						p_q    <= r_p;
						frac_q <= '0;
						cnt_q  <= '0;
						dest_q <= 1'b0;
						if (r_tsm > tsm_q[r_didx]) tsm_q[r_didx] <= r_tsm;
						if (r_cur == '0) begin
							shaped_q <= $signed({r_x[15], r_x, 8'b0});
							state_q  <= ST_R_ACC;
						end else if (r_x == '0) begin
							shaped_q <= '0;
							state_q  <= ST_R_ACC;
						end else if (r_cur[15]) begin
							state_q <= ST_R_EDIV;
						end else begin
							e16_q   <= e16_pos;
							state_q <= ST_R_LOG;
						end
					end
				end
				ST_R_EDIV: begin
					if (div_rsp.done) begin
						e16_q   <= div_rsp.quot[17:0];
						state_q <= ST_R_LOG;
					end
				end
				ST_R_LOG: begin
					y_q    <= y2[31] ? y2[31:1] : y2[30:0];
					frac_q <= {frac_q[14:0], y2[31]};
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= ST_R_LMUL;
				end
				ST_R_LMUL: begin
					ey_q    <= DIV_NW'(mul_p[37:2]);
					rexp_q  <= Q30_ONE;
					k_q     <= 5'd1;
					state_q <= ST_X_LOOP;
				end
				ST_X_LOOP: begin
					if (fbit) rexp_q <= rnd[60:30];
					if (k_q == 5'd30) state_q <= ST_X_SHIFT;
					else k_q <= k_q + 5'd1;
				end
				ST_X_SHIFT: begin
					if (dest_q) begin
						alpha_q <= Q30_ONE - rs;
						state_q <= ST_D_UPD;
					end else begin
						shaped_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
						state_q  <= ST_R_ACC;
					end
				end
				ST_R_ACC: begin
					acc_q[dst_q[DIDX_W-1:0]] <= acc_q[dst_q[DIDX_W-1:0]] + mul_p[42:0];
					rc_q    <= rc_q + 1'b1;
					state_q <= ST_R_LOAD;
				end
				ST_D_LOAD: begin
					if (d_q == DCNT_W'(DESTINATIONS)) begin
						state_q <= ST_IDLE;
					end else begin
						t_q <= t_sat;
						if (d_smooth) begin
							state_q <= ST_D_DIV;
						end else begin
							alpha_q <= Q30_ONE;
							state_q <= ST_D_UPD;
						end
					end
				end
				ST_D_DIV: begin
					if (div_rsp.done) begin
						ey_q    <= div_rsp.quot;
						rexp_q  <= Q30_ONE;
						k_q     <= 5'd1;
						dest_q  <= 1'b1;
						state_q <= ST_X_LOOP;
					end
				end
				ST_D_UPD: begin
					sm_q[d_idx] <= s_sat;
					val_q       <= v_sat;
					state_q     <= ST_D_EMIT;
				end
				ST_D_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= val_q;
						m_tuser_q  <= 3'(d_q);
						m_tlast_q  <= (d_q == DCNT_W'(DESTINATIONS - 1));
						d_q        <= d_q + 1'b1;
						state_q    <= ST_D_LOAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_last_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tlast_q) |-> (m_tuser_q == 3'(DESTINATIONS - 1)))
		else $error("last flag on wrong destination");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X_LOOP) |-> (k_q >= 5'd1 && k_q <= 5'd30))
		else $error("exp2 step index out of range");

	a_acc_dst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_R_ACC) |-> ({1'b0, dst_q} < 4'(DESTINATIONS)))
		else $error("accumulate into missing destination");

endmodule
